/* hw/rtl/trn_pkg.sv */
package trn_pkg;

    localparam int SUB_BUF_DEPTH = 64;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);

    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_REPLY  = 2'd1;
    localparam logic [1:0] KIND_RESIZE = 2'd2;

    localparam logic [2:0] OP_KEY    = 3'd0;
    localparam logic [2:0] OP_AYT    = 3'd1;
    localparam logic [2:0] OP_ENV    = 3'd2;
    localparam logic [2:0] OP_DONT   = 3'd3;
    localparam logic [2:0] OP_WONT   = 3'd4;
    localparam logic [2:0] OP_RESIZE = 3'd5;

    localparam logic [7:0] B_IAC  = 8'hff;
    localparam logic [7:0] B_DONT = 8'hfe;
    localparam logic [7:0] B_DO   = 8'hfd;
    localparam logic [7:0] B_WONT = 8'hfc;
    localparam logic [7:0] B_WILL = 8'hfb;
    localparam logic [7:0] B_SB   = 8'hfa;
    localparam logic [7:0] B_AYT  = 8'hf6;
    localparam logic [7:0] B_NOP  = 8'hf1;
    localparam logic [7:0] B_SE   = 8'hf0;
    localparam logic [7:0] B_DEL  = 8'h7f;
    localparam logic [7:0] OPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;
    localparam logic [7:0] OPT_NAWS = 8'd31;
    localparam logic [7:0] OPT_ENV  = 8'd39;

    localparam logic [2:0] REG_DEF_W  = 3'd0;
    localparam logic [2:0] REG_DEF_H  = 3'd1;
    localparam logic [2:0] REG_MAX    = 3'd2;
    localparam logic [2:0] REG_BS     = 3'd3;
    localparam logic [2:0] REG_RET    = 3'd4;

    typedef struct packed {
        logic [15:0] def_w;
        logic [15:0] def_h;
        logic [15:0] max_size;
        logic [7:0]  bs_code;
        logic [7:0]  ret_code;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  data;
        logic [15:0] width;
        logic [15:0] height;
    } t_cmd;

    function automatic logic [3:0] cmd_len(input logic [2:0] op);
        case (op)
            OP_AYT:  cmd_len = 4'd9;
            OP_ENV:  cmd_len = 4'd6;
            OP_DONT: cmd_len = 4'd3;
            OP_WONT: cmd_len = 4'd3;
            default: cmd_len = 4'd1;
        endcase
    endfunction

    function automatic logic [1:0] cmd_kind(input logic [2:0] op);
        case (op)
            OP_KEY:    cmd_kind = KIND_KEY;
            OP_RESIZE: cmd_kind = KIND_RESIZE;
            default:   cmd_kind = KIND_REPLY;
        endcase
    endfunction

    function automatic logic [7:0] cmd_byte(input logic [2:0] op, input logic [3:0] idx,
                                            input logic [7:0] d);
        cmd_byte = 8'd0;
        case (op)
            OP_KEY: cmd_byte = d;
            OP_AYT: begin
                case (idx)
                    4'd0:    cmd_byte = 8'd13;
                    4'd1:    cmd_byte = 8'd10;
                    4'd2:    cmd_byte = 8'h5b;
                    4'd3:    cmd_byte = 8'h59;
                    4'd4:    cmd_byte = 8'h65;
                    4'd5:    cmd_byte = 8'h53;
                    4'd6:    cmd_byte = 8'h5d;
                    4'd7:    cmd_byte = 8'd13;
                    default: cmd_byte = 8'd10;
                endcase
            end
            OP_ENV: begin
                case (idx)
                    4'd0:    cmd_byte = B_IAC;
                    4'd1:    cmd_byte = B_SB;
                    4'd2:    cmd_byte = OPT_ENV;
                    4'd3:    cmd_byte = 8'd1;
                    4'd4:    cmd_byte = B_IAC;
                    default: cmd_byte = B_SE;
                endcase
            end
            OP_DONT: begin
                case (idx)
                    4'd0:    cmd_byte = B_IAC;
                    4'd1:    cmd_byte = B_DONT;
                    default: cmd_byte = d;
                endcase
            end
            OP_WONT: begin
                case (idx)
                    4'd0:    cmd_byte = B_IAC;
                    4'd1:    cmd_byte = B_WONT;
                    default: cmd_byte = d;
                endcase
            end
            default: cmd_byte = 8'd0;
        endcase
    endfunction

endpackage

/* hw/rtl/trn_front.sv */
module trn_front import trn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [3:0] ST_DATA    = 4'd0;
    localparam logic [3:0] ST_IAC     = 4'd1;
    localparam logic [3:0] ST_WILL    = 4'd2;
    localparam logic [3:0] ST_DO      = 4'd3;
    localparam logic [3:0] ST_NAWS    = 4'd4;
    localparam logic [3:0] ST_ENV     = 4'd5;
    localparam logic [3:0] ST_ENV_IS  = 4'd6;
    localparam logic [3:0] ST_ENV_VAR = 4'd7;
    localparam logic [3:0] ST_ENV_VAL = 4'd8;
    localparam logic [3:0] ST_ARG     = 4'd9;

    logic [3:0]  r_state, n_state;
    logic [7:0]  r_sub, n_sub;
    logic [15:0] r_w, n_w, r_h, n_h;
    logic [7:0]  r_buf [1:5];
    logic [7:0]  n_buf [1:5];
    logic [7:0]  z_buf [1:5];
    logic        wr0, wr1;
    logic [7:0]  idx0, idx1, v0, v1;
    logic        user_now, user_put;
    logic [15:0] naws_w, naws_h, clamp_w, clamp_h;
    logic [7:0]  c;

    function automatic logic is_user(input logic [7:0] b1, input logic [7:0] b2,
                                     input logic [7:0] b3, input logic [7:0] b4,
                                     input logic [7:0] b5);
        is_user = (b1 == 8'h55) && (b2 == 8'h53) && (b3 == 8'h45) &&
                  (b4 == 8'h52) && (b5 == 8'd0);
    endfunction

    assign c = i_rx_byte;

    always_comb begin
        for (int k = 1; k <= 5; k++) begin
            z_buf[k] = (r_sub == 8'(k)) ? 8'd0 : r_buf[k];
        end
    end

    assign user_now = is_user(r_buf[1], r_buf[2], r_buf[3], r_buf[4], r_buf[5]);
    assign user_put = is_user(z_buf[1], z_buf[2], z_buf[3], z_buf[4], z_buf[5]);

    assign naws_w = {r_buf[1], r_buf[2]};
    assign naws_h = {r_buf[3], r_buf[4]};

    always_comb begin
        logic [15:0] tw, th;
        tw = (naws_w <= 16'd1) ? i_cfg.def_w : naws_w;
        th = (naws_h <= 16'd2) ? i_cfg.def_h : naws_h;
        clamp_w = (tw > i_cfg.max_size) ? i_cfg.max_size : tw;
        clamp_h = (th > i_cfg.max_size) ? i_cfg.max_size : th;
    end

    always_comb begin
        n_state = r_state;
        n_sub   = r_sub;
        n_w     = r_w;
        n_h     = r_h;
        o_push  = 1'b0;
        o_cmd.op   = OP_KEY;
        o_cmd.data = 8'd0;
        wr0 = 1'b0;
        wr1 = 1'b0;
        idx0 = r_sub;
        idx1 = 8'd1;
        v0 = 8'd0;
        v1 = 8'd0;
        case (r_state)
            ST_DATA: begin
                if (c == B_IAC) begin
                    n_state = ST_IAC;
                end else if (c == B_DEL) begin
                    o_push = 1'b1;
                    o_cmd.data = i_cfg.bs_code;
                end else if (c != 8'd0 && c != 8'd10 && c < B_DEL) begin
                    o_push = 1'b1;
                    o_cmd.data = c;
                end
            end
            ST_IAC: begin
                if (c == B_IAC) begin
                    n_state = ST_DATA;
                    o_push = 1'b1;
                end else if (c == B_AYT) begin
                    n_state = ST_DATA;
                    o_push = 1'b1;
                    o_cmd.op = OP_AYT;
                end else if (c == B_NOP) begin
                    n_state = ST_DATA;
                end else if (c == B_SB) begin
                    if (r_sub != 8'hff) n_sub = r_sub + 8'd1;
                end else if (c == B_SE) begin
                    if (r_sub != 8'd0) n_sub = r_sub - 8'd1;
                    n_state = ST_DATA;
                end else if (c == B_WILL) begin
                    n_state = ST_WILL;
                end else if (c == B_DO) begin
                    n_state = ST_DO;
                end else if (c == OPT_NAWS) begin
                    n_state = ST_NAWS;
                end else if (c == OPT_ENV) begin
                    n_state = ST_ENV;
                end else begin
                    n_state = ST_ARG;
                end
            end
            ST_WILL: begin
                if (c == OPT_ENV) begin
                    o_push = 1'b1;
                    o_cmd.op = OP_ENV;
                end else if (c != OPT_NAWS) begin
                    o_push = 1'b1;
                    o_cmd.op = OP_DONT;
                    o_cmd.data = c;
                end
                n_state = ST_DATA;
            end
            ST_DO: begin
                if (c != OPT_SGA && c != OPT_ECHO) begin
                    o_push = 1'b1;
                    o_cmd.op = OP_WONT;
                    o_cmd.data = c;
                end
                n_state = ST_DATA;
            end
            ST_NAWS: begin
                if (r_sub <= 8'd4) begin
                    wr0 = 1'b1;
                    v0 = c;
                    n_sub = r_sub + 8'd1;
                end else begin
                    n_w = clamp_w;
                    n_h = clamp_h;
                    n_sub = 8'd0;
                    n_state = ST_IAC;
                    o_push = 1'b1;
                    o_cmd.op = OP_RESIZE;
                end
            end
            ST_ENV: begin
                if (c == 8'd0) n_state = ST_ENV_IS;
                n_sub = 8'd1;
                wr1 = 1'b1;
            end
            ST_ENV_IS: begin
                if (c == 8'd0 || c == 8'd2 || c == 8'd3) begin
                    n_sub = 8'd1;
                    wr1 = 1'b1;
                    n_state = ST_ENV_VAR;
                end else if (c == B_IAC) begin
                    n_state = ST_IAC;
                end else begin
                    n_state = ST_DATA;
                end
            end
            ST_ENV_VAR: begin
                if (c == 8'd1) begin
                    wr0 = 1'b1;
                    if (r_sub != 8'hff) n_sub = r_sub + 8'd1;
                    n_state = ST_ENV_VAL;
                end else if (c == B_IAC) begin
                    n_state = ST_IAC;
                end else if (r_sub < 8'(SUB_BUF_DEPTH - 2)) begin
                    wr0 = 1'b1;
                    v0 = c;
                    n_sub = r_sub + 8'd1;
                    wr1 = 1'b1;
                    idx1 = r_sub + 8'd1;
                end
            end
            ST_ENV_VAL: begin
                if (c <= 8'd3 || c == B_IAC) begin
                    wr0 = 1'b1;
                    n_state = (c == B_IAC) ? ST_IAC : ST_ENV_VAR;
                    n_sub = 8'd1;
                    wr1 = 1'b1;
                    if (user_put) begin
                        o_push = 1'b1;
                        o_cmd.data = i_cfg.ret_code;
                    end
                end else if (user_now) begin
                    o_push = 1'b1;
                    o_cmd.data = c;
                end
            end
            ST_ARG: begin
                n_state = (r_sub != 8'd0) ? ST_IAC : ST_DATA;
            end
            default: begin
                n_state = ST_DATA;
            end
        endcase
        o_cmd.width  = n_w;
        o_cmd.height = n_h;
        o_push = o_push & i_accept;
    end

    // apply buffer writes in model order; only entries 1..5 are ever read back
    always_comb begin
        for (int k = 1; k <= 5; k++) begin
            n_buf[k] = r_buf[k];
            if (wr0 && idx0 == 8'(k)) n_buf[k] = v0;
            if (wr1 && idx1 == 8'(k)) n_buf[k] = v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_DATA;
            r_sub   <= 8'd0;
            r_w     <= 16'd80;
            r_h     <= 16'd24;
        end else if (i_accept) begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_w     <= n_w;
            r_h     <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int k = 1; k <= 5; k++) r_buf[k] <= n_buf[k];
        end
    end

endmodule

/* hw/rtl/trn_queue.sv */
module trn_queue import trn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_AW:0]    r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

/* hw/rtl/trn_back.sv */
module trn_back import trn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_width,
    output logic [15:0] o_height,
    output logic        o_last
);

    logic [3:0] r_idx;
    logic       adv, is_last;

    assign adv     = !i_empty && (!o_valid || !i_stall);
    assign is_last = (r_idx == cmd_len(i_cmd.op) - 4'd1);
    assign o_pop   = adv && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else begin
            if (adv) begin
                o_valid <= 1'b1;
                r_idx   <= is_last ? 4'd0 : r_idx + 4'd1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_kind      <= cmd_kind(i_cmd.op);
            o_data_byte <= cmd_byte(i_cmd.op, r_idx, i_cmd.data);
            o_width     <= i_cmd.width;
            o_height    <= i_cmd.height;
            o_last      <= is_last;
        end
    end

    a_idx_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 4'd0 |-> !i_empty)
        else $error("burst index set with empty queue");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> r_idx < cmd_len(i_cmd.op))
        else $error("burst index past command length");
    a_resize: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_RESIZE |-> o_last && o_data_byte == 8'd0)
        else $error("resize beat malformed");

endmodule

/* hw/rtl/telnet_receive_negotiator_top.sv */
// Path: an accepted byte is written into the command queue, and the queue head is then
// registered onto the output as the first result beat.
// Throughput: one byte per cycle; result beats leave the output one at a time,
// so reply bursts (up to 9 beats) drain through a 4-entry command queue and the
// input stalls only while that queue is full.
// Reset: synchronous active-low; parser to plain data, window 80x24,
// registers to their defaults, queue and output emptied.
module telnet_receive_negotiator_top import trn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_width,
    output logic [15:0] o_height,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg;
    t_cmd       f_cmd, q_cmd;
    logic       accept, push, q_full, q_empty, pop;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.def_w    <= 16'd80;
            r_cfg.def_h    <= 16'd24;
            r_cfg.max_size <= 16'd250;
            r_cfg.bs_code  <= 8'd8;
            r_cfg.ret_code <= 8'd13;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_DEF_W: r_cfg.def_w    <= pwdata[15:0];
                REG_DEF_H: r_cfg.def_h    <= pwdata[15:0];
                REG_MAX:   r_cfg.max_size <= pwdata[15:0];
                REG_BS:    r_cfg.bs_code  <= pwdata[7:0];
                REG_RET:   r_cfg.ret_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEF_W: prdata = {16'd0, r_cfg.def_w};
            REG_DEF_H: prdata = {16'd0, r_cfg.def_h};
            REG_MAX:   prdata = {16'd0, r_cfg.max_size};
            REG_BS:    prdata = {24'd0, r_cfg.bs_code};
            REG_RET:   prdata = {24'd0, r_cfg.ret_code};
            default:   prdata = 32'd0;
        endcase
    end

    trn_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_push    (push),
        .o_cmd     (f_cmd)
    );

    trn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    trn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_width     (o_width),
        .o_height    (o_height),
        .o_last      (o_last)
    );

endmodule
